### hw/rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// Triangle face normal package
// Sideband type that travels beside each component through the normaliser.
// ----------------------------------------------------------------------------
package tfn_pkg;

  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } tfn_side_t;

endpackage

### hw/rtl/tfn_lane.sv
// ----------------------------------------------------------------------------
// Triangle face normal component lane
// Pipelined restoring divider of c^2 by |c|^2, one quotient bit per stage,
// followed by a pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tfn_lane #(
  parameter int SW = 72,
  parameter int QW = 31,
  parameter int OW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  tfn_pkg::tfn_side_t     side_in,
  input  logic [SW-1:0]          c2,
  input  logic [SW-1:0]          s,
  output tfn_pkg::tfn_side_t     side_out,
  output logic signed [OW-1:0]   q
);
  import tfn_pkg::*;

  localparam int NS = (QW + 1) / 2;
  localparam int RW = 2 * NS;

  logic [SW-1:0] dr [QW];
  logic [SW-1:0] ds [QW];
  logic [QW-1:0] dt [QW];
  tfn_side_t     dside [QW];

  logic [RW-1:0] rm [NS+1];
  logic [RW-1:0] rs [NS+1];
  tfn_side_t     sside [NS+1];

  logic [RW-1:0] rnd;

  // The integer quotient bit is taken first; the rest follow by doubling.
  always_ff @(posedge clk) begin
    if (rst) begin
      dside[0] <= '0;
    end else if (en) begin
      dside[0] <= side_in;
      ds[0]    <= s;
      if (c2 >= s) begin
        dr[0] <= c2 - s;
        dt[0] <= QW'(1);
      end else begin
        dr[0] <= c2;
        dt[0] <= '0;
      end
    end
  end

  for (genvar i = 1; i < QW; i++) begin : g_div
    logic [SW-1:0] rest;
    logic          ge;
    assign rest = ds[i-1] - dr[i-1];
    assign ge   = dr[i-1] >= rest;
    always_ff @(posedge clk) begin
      if (rst) begin
        dside[i] <= '0;
      end else if (en) begin
        dside[i] <= dside[i-1];
        ds[i]    <= ds[i-1];
        dr[i]    <= ge ? (dr[i-1] - rest) : {dr[i-1][SW-2:0], 1'b0};
        dt[i]    <= {dt[i-1][QW-2:0], ge};
      end
    end
  end

  assign rm[0]    = RW'(dt[QW-1]);
  assign rs[0]    = '0;
  assign sside[0] = dside[QW-1];

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NS - 1 - j));
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = rs[j] + BIT;
    assign ge    = rm[j] >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sside[j+1] <= '0;
      end else if (en) begin
        sside[j+1] <= sside[j];
        rm[j+1]    <= ge ? (rm[j] - trial) : rm[j];
        rs[j+1]    <= ge ? ((rs[j] >> 1) + BIT) : (rs[j] >> 1);
      end
    end
  end

  // Halving the root of four times the ratio rounds to nearest.
  assign rnd = (rs[NS] + RW'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= sside[NS];
      if (sside[NS].zero) begin
        q <= '0;
      end else if (sside[NS].neg) begin
        q <= OW'(-rnd);
      end else begin
        q <= OW'(rnd);
      end
    end
  end

endmodule

### hw/rtl/triangle_face_normal_top.sv
// ----------------------------------------------------------------------------
// Triangle face normal
// Unit normal of a triangle from its three vertices, fully pipelined.
// ----------------------------------------------------------------------------
// One word on the input channel carries the three vertex positions in signed
// fixed point. One word on the output channel carries the unit normal in
// signed Q1.NORMAL_FRAC_BITS and a degenerate flag, set when the edges are
// parallel and the normal is then zero.
// A word is moved when valid is high and stall is low on its channel.
// Pipeline: six stages form the edges, the cross product and the squared
// length, then one stage per quotient bit of the divider, one per root bit
// of the square root, and a final output register.
// Throughput is one triangle per cycle while the output is not stalled.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised; empty slots are kept as bubbles.
// Reset clears every valid bit; the block carries no state between words.
// ----------------------------------------------------------------------------
module triangle_face_normal_top #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     first_x,
  input  logic signed [COORD_WIDTH-1:0]     first_y,
  input  logic signed [COORD_WIDTH-1:0]     first_z,
  input  logic signed [COORD_WIDTH-1:0]     second_x,
  input  logic signed [COORD_WIDTH-1:0]     second_y,
  input  logic signed [COORD_WIDTH-1:0]     second_z,
  input  logic signed [COORD_WIDTH-1:0]     third_x,
  input  logic signed [COORD_WIDTH-1:0]     third_y,
  input  logic signed [COORD_WIDTH-1:0]     third_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
  output logic                              degenerate
);
  import tfn_pkg::*;

  localparam int EW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * EW;
  localparam int CXW = (2 * COORD_WIDTH + 3 > 64) ? 64 : 2 * COORD_WIDTH + 3;
  localparam int MW  = CXW;
  localparam int H   = (MW + 1) / 2;
  localparam int HW  = MW - H;
  localparam int SQW = 2 * MW;
  localparam int SW  = (2 * MW + 2 > 128) ? 128 : 2 * MW + 2;
  localparam int QW  = 2 * NORMAL_FRAC_BITS + 3;
  localparam int OW  = NORMAL_FRAC_BITS + 2;

  logic en;
  logic [5:0] vld;

  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];
  logic signed [PW-1:0]  prod [6];
  logic [MW-1:0]         mag [3];
  logic [2:0]            neg_c, neg_d, neg_e, neg_f;
  logic                  deg_c, deg_d, deg_e, deg_f;
  logic [2*H-1:0]        pp_ll [3];
  logic [H+HW-1:0]       pp_lh [3];
  logic [2*HW-1:0]       pp_hh [3];
  logic [SQW-1:0]        sq [3];
  logic [SW-1:0]         sq_f [3];
  logic [SW-1:0]         s_f;

  logic [CXW-1:0]        cw [3];
  tfn_side_t             side_out [3];
  logic signed [OW-1:0]  q [3];

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  // Edges from the first vertex.
  always_ff @(posedge clk) begin
    if (en) begin
      e1[0] <= EW'(second_x) - EW'(first_x);
      e1[1] <= EW'(second_y) - EW'(first_y);
      e1[2] <= EW'(second_z) - EW'(first_z);
      e2[0] <= EW'(third_x) - EW'(first_x);
      e2[1] <= EW'(third_y) - EW'(first_y);
      e2[2] <= EW'(third_z) - EW'(first_z);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= PW'(e1[1] * e2[2]);
      prod[1] <= PW'(e1[2] * e2[1]);
      prod[2] <= PW'(e1[2] * e2[0]);
      prod[3] <= PW'(e1[0] * e2[2]);
      prod[4] <= PW'(e1[0] * e2[1]);
      prod[5] <= PW'(e1[1] * e2[0]);
    end
  end

  // The cross product wraps to 64 bits at the widest coordinates.
  for (genvar k = 0; k < 3; k++) begin : g_cross
    logic signed [PW:0] diff;
    assign diff  = (PW+1)'(prod[2*k]) - (PW+1)'(prod[2*k+1]);
    assign cw[k] = diff[CXW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg_c[k] <= cw[k][CXW-1];
        mag[k]   <= cw[k][CXW-1] ? (~cw[k] + CXW'(1)) : cw[k];
      end
      deg_c <= (cw[0] == '0) && (cw[1] == '0) && (cw[2] == '0);
    end
  end

  // Squares are split into half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pp_ll[k] <= (2*H)'(mag[k][H-1:0] * mag[k][H-1:0]);
        pp_lh[k] <= (H+HW)'(mag[k][H-1:0] * mag[k][MW-1:H]);
        pp_hh[k] <= (2*HW)'(mag[k][MW-1:H] * mag[k][MW-1:H]);
      end
      neg_d <= neg_c;
      deg_d <= deg_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= (SQW'(pp_hh[k]) << (2 * H)) + (SQW'(pp_lh[k]) << (H + 1))
                 + SQW'(pp_ll[k]);
      end
      neg_e <= neg_d;
      deg_e <= deg_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_f[k] <= SW'(sq[k]);
      end
      s_f   <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      neg_f <= neg_e;
      deg_f <= deg_e;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tfn_side_t side_in;
    assign side_in = '{valid: vld[5], neg: neg_f[k], zero: deg_f};
    tfn_lane #(
      .SW (SW),
      .QW (QW),
      .OW (OW)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (side_in),
      .c2       (sq_f[k]),
      .s        (s_f),
      .side_out (side_out[k]),
      .q        (q[k])
    );
  end

  assign out_valid  = side_out[0].valid;
  assign degenerate = side_out[0].zero;
  assign normal_x   = q[0];
  assign normal_y   = q[1];
  assign normal_z   = q[2];

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate word with a non-zero normal");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    side_out[0].valid == side_out[1].valid && side_out[0].valid == side_out[2].valid)
    else $error("component lanes out of step");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input held without a stalled result");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Triangle face normal testbench
// Drives triangles through the valid/stall channel with random gaps and
// output stalls, predicts each unit normal in exact integer arithmetic and
// compares every returned word field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int FB = 14;
  localparam int OW = FB + 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t tri_t [9];

  typedef struct {
    logic signed [OW-1:0] nx, ny, nz;
    logic                 degen;
  } normal_t;

  class normal_board;
    normal_t pending[$];
    int      errors = 0;
    int      checked = 0;
    int      degen_seen = 0;

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Exact normal: the cross product of the edges from the first vertex scaled to unit length.
    function void note(tri_t p);
      longint        e1 [3], e2 [3], c [3];
      logic [127:0]  sq [3], total, quot;
      longint unsigned m, q;
      normal_t       n;
      for (int i = 0; i < 3; i++) begin
        e1[i] = longint'(p[3+i]) - longint'(p[i]);
        e2[i] = longint'(p[6+i]) - longint'(p[i]);
      end
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
        m = (c[i] < 0) ? longint'(-c[i]) : c[i];
        sq[i] = 128'(m) * 128'(m);
      end
      total = sq[0] + sq[1] + sq[2];
      n.degen = (total == 0);
      n.nx = '0;
      n.ny = '0;
      n.nz = '0;
      if (!n.degen) begin
        for (int i = 0; i < 3; i++) begin
          quot = (sq[i] << (2 * FB + 2)) / total;
          q = (int_sqrt(64'(quot)) + 1) >> 1;
          if (c[i] < 0) q = -q;
          case (i)
            0: n.nx = q[OW-1:0];
            1: n.ny = q[OW-1:0];
            default: n.nz = q[OW-1:0];
          endcase
        end
      end
      pending.push_back(n);
    endfunction

    task report(string what, logic [OW-1:0] got, logic [OW-1:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %0d, expected %0d",
               checked, what, $signed(got), $signed(want));
    endtask

    task check(normal_t r);
      normal_t w;
      if (pending.size() == 0) begin
        errors++;
        $display("unexpected result word %0d with nothing pending", checked);
      end else begin
        w = pending.pop_front();
        if (r.nx !== w.nx) report("normal_x", r.nx, w.nx);
        if (r.ny !== w.ny) report("normal_y", r.ny, w.ny);
        if (r.nz !== w.nz) report("normal_z", r.nz, w.nz);
        if (r.degen !== w.degen) report("degenerate", r.degen, w.degen);
        if (w.degen) degen_seen++;
      end
      checked++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  coord_t first_x = 0, first_y = 0, first_z = 0;
  coord_t second_x = 0, second_y = 0, second_z = 0;
  coord_t third_x = 0, third_y = 0, third_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [OW-1:0] normal_x, normal_y, normal_z;
  logic degenerate;

  normal_board board = new();
  int sent = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  triangle_face_normal_top #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) u_dut (
    .clk, .rst, .in_valid, .in_stall,
    .first_x, .first_y, .first_z, .second_x, .second_y, .second_z,
    .third_x, .third_y, .third_z,
    .out_valid, .out_stall, .normal_x, .normal_y, .normal_z, .degenerate
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        board.note('{first_x, first_y, first_z, second_x, second_y, second_z,
                     third_x, third_y, third_z});
      if (out_valid && !out_stall)
        board.check('{normal_x, normal_y, normal_z, degenerate});
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // The receiver stalls in bursts; some stretches run with no stall at all.
  always @(posedge clk) begin
    int hold;
    if (hold > 0) begin
      hold <= hold - 1;
    end else begin
      out_stall <= ($urandom_range(2) == 0);
      hold <= ($urandom_range(4) == 0) ? 0 : gap_len();
    end
  end

  task automatic send(tri_t p, bit idle_after);
    first_x <= p[0]; first_y <= p[1]; first_z <= p[2];
    second_x <= p[3]; second_y <= p[4]; second_z <= p[5];
    third_x <= p[6]; third_y <= p[7]; third_z <= p[8];
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (idle_after) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        in_valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  initial begin
    tri_t p;
    coord_t mx, mn;
    int mode;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: all-zero, coincident and collinear points, axis planes,
    // corners of the range and alternating bit patterns.
    send('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1);
    send('{mx, mn, 7, mx, mn, 7, mx, mn, 7}, 1);
    send('{0, 0, 0, 100, 200, 300, 200, 400, 600}, 1);
    send('{mn, mn, mn, mx, mx, mx, 0, 0, 0}, 0);
    send('{0, 0, 0, 4096, 0, 0, 0, 4096, 0}, 0);
    send('{0, 0, 0, 0, 4096, 0, 4096, 0, 0}, 1);
    send('{0, 0, 0, 0, 0, 4096, 4096, 0, 0}, 1);
    send('{0, 0, 0, 0, 4096, 0, 0, 0, 4096}, 0);
    send('{mn, mn, mn, mx, mn, mn, mn, mx, mn}, 1);
    send('{mx, mx, mx, mn, mx, mx, mx, mn, mx}, 0);
    send('{mx, mn, mx, mn, mx, mn, mx, mx, mn}, 1);
    send('{mn, mx, mn, mx, mn, mx, mn, mn, mx}, 0);
    send('{16'sh5555, 16'sh2aaa, 16'sh5555, 16'shaaaa, 16'shd555, 16'shaaaa,
           16'sh5555, 16'shaaaa, 16'sh2aaa}, 1);
    send('{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
           16'sh2aaa, 16'sh5555, 16'shd555}, 1);
    send('{1, 0, 0, 0, 1, 0, 0, 0, 1}, 0);
    send('{0, 0, 0, 1, 0, 0, 0, 1, 1}, 1);
    send('{0, 0, 0, 3, 4, 0, 0, 0, 5}, 1);
    send('{0, 0, 0, mx, 0, 0, mn, 1, 0}, 1);
    in_valid <= 0;

    // Let the pipeline drain completely before the random traffic.
    while (board.checked < sent) @(posedge clk);

    for (int n = 0; n < 500; n++) begin
      mode = $urandom_range(9);
      for (int i = 0; i < 9; i++)
        p[i] = rand_coord(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
      // Now and then make the third point collinear with the first two.
      if ($urandom_range(15) == 0)
        for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
      send(p, 1);
    end
    in_valid <= 0;

    while (board.checked < sent) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("tb: %0d triangles sent, %0d normals checked, %0d degenerate",
             sent, board.checked, board.degen_seen);
    $display("tb: covered axis planes, range corners, collinear points, random data");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: timeout with %0d results outstanding", board.pending.size());
    $display("tb: done, errors");
    $finish;
  end
endmodule
